// ----- rtl/bcd_clock_to_unix_epoch_top_assert.svh -----
// Assertion macros shared by the RTL. Expect clk and arst_n in scope.
`ifndef BCD_CLOCK_TO_UNIX_EPOCH_TOP_ASSERT_SVH
`define BCD_CLOCK_TO_UNIX_EPOCH_TOP_ASSERT_SVH

// Same-cycle implication.
`define BTUE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("btue assertion failed");

// Implication after a fixed number of cycles.
`define BTUE_ASSERT_LAT(label, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("btue latency assertion failed");

`endif

// ----- rtl/btue_pkg.sv -----
`timescale 1ns / 1ps
package btue_pkg;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ABSENT   = 3'd1;
	localparam logic [2:0] ST_READFAIL = 3'd2;
	localparam logic [2:0] ST_VLOW     = 3'd3;
	localparam logic [2:0] ST_YEAR     = 3'd4;

	localparam logic [1:0] CFG_CHIP_PRESENT = 2'd0;
	localparam logic [1:0] CFG_MIN_YEAR     = 2'd1;
	localparam logic [1:0] CFG_YEAR_LIMIT   = 2'd2;

	localparam int YEAR_W = 12;

	typedef struct packed {
		logic       read_ok;
		logic [7:0] seconds_reg;
		logic [7:0] minutes_reg;
		logic [7:0] hours_reg;
		logic [7:0] day_reg;
		logic [7:0] month_reg;
		logic [7:0] year_reg;
	} snap_t;

	typedef struct packed {
		logic [31:0] epoch_seconds;
		logic [2:0]  status;
		logic        voltage_low;
	} result_t;

	typedef struct packed {
		logic              chip_present;
		logic [YEAR_W-1:0] min_year;
		logic [YEAR_W-1:0] year_limit;
	} cfg_t;

	// after decode
	typedef struct packed {
		logic [2:0]        status;
		logic              vlow;
		logic [YEAR_W-1:0] year_adj;
		logic [4:0]        shifted;
		logic [5:0]        mday;
		logic [5:0]        hour;
		logic [6:0]        minute;
		logic [6:0]        second;
	} dec_t;

	// products of the year
	typedef struct packed {
		logic [2:0]  status;
		logic        vlow;
		logic [19:0] y365;
		logic [9:0]  y4;
		logic [5:0]  y100;
		logic [9:0]  doyb;
		logic [17:0] tod;
	} mid_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               vlow;
		logic signed [17:0] days;
		logic [17:0]        tod;
	} sum_t;

	function automatic logic [7:0] bcd_val(input logic [7:0] b);
		logic [7:0] hi;
		hi = {4'd0, b[7:4]};
		return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
	endfunction

	// (153 * s + 2) / 5 for a March-based month offset s
	function automatic logic [9:0] doy_off(input logic [4:0] s);
		logic [9:0] v;
		case (s)
			5'd0:    v = 10'd0;
			5'd1:    v = 10'd31;
			5'd2:    v = 10'd61;
			5'd3:    v = 10'd92;
			5'd4:    v = 10'd122;
			5'd5:    v = 10'd153;
			5'd6:    v = 10'd184;
			5'd7:    v = 10'd214;
			5'd8:    v = 10'd245;
			5'd9:    v = 10'd275;
			5'd10:   v = 10'd306;
			5'd11:   v = 10'd337;
			5'd12:   v = 10'd367;
			5'd13:   v = 10'd398;
			5'd14:   v = 10'd428;
			5'd15:   v = 10'd459;
			5'd16:   v = 10'd490;
			5'd17:   v = 10'd520;
			5'd18:   v = 10'd551;
			5'd19:   v = 10'd581;
			5'd20:   v = 10'd612;
			5'd21:   v = 10'd643;
			5'd22:   v = 10'd673;
			default: v = 10'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/btue_decode.sv -----
`timescale 1ns / 1ps
module btue_decode import btue_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid,
	input  snap_t snap,
	input  cfg_t  cfg,
	output logic  valid_s1,
	output dec_t  dec_s1
);

	logic [7:0]        sec8, min8, hour8, day8, mon8, yr8;
	logic [YEAR_W-1:0] year_full;
	logic [4:0]        mon;
	logic              early;
	dec_t              dec;

	always_comb begin
		sec8  = bcd_val({1'b0, snap.seconds_reg[6:0]});
		min8  = bcd_val({1'b0, snap.minutes_reg[6:0]});
		hour8 = bcd_val({2'b0, snap.hours_reg[5:0]});
		day8  = bcd_val({2'b0, snap.day_reg[5:0]});
		mon8  = bcd_val({3'b0, snap.month_reg[4:0]});
		yr8   = bcd_val(snap.year_reg);
		// century bit set means 19xx
		year_full = {4'd0, yr8} + (snap.month_reg[7] ? 12'd1900 : 12'd2000);
		mon   = mon8[4:0];
		early = (mon <= 5'd2);

		dec.year_adj = year_full - {11'd0, early};
		dec.shifted  = early ? (mon + 5'd9) : (mon - 5'd3);
		dec.mday     = day8[5:0];
		dec.hour     = hour8[5:0];
		dec.minute   = min8[6:0];
		dec.second   = sec8[6:0];
		dec.vlow     = cfg.chip_present & snap.read_ok & snap.seconds_reg[7];

		if (!cfg.chip_present) begin
			dec.status = ST_ABSENT;
		end else if (!snap.read_ok) begin
			dec.status = ST_READFAIL;
		end else if (snap.seconds_reg[7]) begin
			dec.status = ST_VLOW;
		end else if (year_full < cfg.min_year || year_full >= cfg.year_limit) begin
			dec.status = ST_YEAR;
		end else begin
			dec.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		dec_s1 <= dec;
	end

endmodule

// ----- rtl/btue_days.sv -----
`timescale 1ns / 1ps
module btue_days import btue_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  dec_t dec_s1,
	output logic valid_s3,
	output sum_t sum_s3
);

	// floor(y / 100) = (y * 5243) >> 19 for any 12-bit y
	localparam logic [24:0] RECIP_100 = 25'd5243;
	// 1970-01-01 offset plus the day-of-month minus one
	localparam logic [20:0] DAY_BIAS = 21'd719469;

	logic [24:0] y_prod;
	logic [19:0] y365;
	logic [17:0] tod;
	logic        valid_s2;
	mid_t        mid_s2;
	logic [20:0] day_sum;

	assign y_prod = {13'd0, dec_s1.year_adj} * RECIP_100;
	assign y365   = {8'd0, dec_s1.year_adj} * 20'd365;
	assign tod    = {12'd0, dec_s1.hour} * 18'd3600 + {11'd0, dec_s1.minute} * 18'd60
		+ {11'd0, dec_s1.second};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		mid_s2.status <= dec_s1.status;
		mid_s2.vlow   <= dec_s1.vlow;
		mid_s2.y365   <= y365;
		mid_s2.y4     <= dec_s1.year_adj[11:2];
		mid_s2.y100   <= y_prod[24:19];
		mid_s2.doyb   <= doy_off(dec_s1.shifted) + {4'd0, dec_s1.mday};
		mid_s2.tod    <= tod;
	end

	// y/400 is (y/100)/4; the true day count fits 18 signed bits
	assign day_sum = {1'b0, mid_s2.y365} + {11'd0, mid_s2.y4} + {17'd0, mid_s2.y100[5:2]}
		+ {11'd0, mid_s2.doyb} - {15'd0, mid_s2.y100} - DAY_BIAS;

	always_ff @(posedge clk) begin
		sum_s3.status <= mid_s2.status;
		sum_s3.vlow   <= mid_s2.vlow;
		sum_s3.days   <= signed'(day_sum[17:0]);
		sum_s3.tod    <= mid_s2.tod;
	end

endmodule

// ----- rtl/btue_scale.sv -----
`timescale 1ns / 1ps
module btue_scale import btue_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s3,
	input  sum_t    sum_s3,
	output logic    done_q,
	output result_t result_q
);

	logic [31:0] days_ext;
	logic [31:0] total;

	// wraps modulo 2^32 like the epoch field
	assign days_ext = {{14{sum_s3.days[17]}}, sum_s3.days};
	assign total    = 32'(days_ext * 32'd86400) + {14'd0, sum_s3.tod};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		result_q.epoch_seconds <= (sum_s3.status == ST_OK) ? total : 32'd0;
		result_q.status        <= sum_s3.status;
		result_q.voltage_low   <= sum_s3.vlow;
	end

endmodule

// ----- rtl/bcd_clock_to_unix_epoch_top.sv -----
`timescale 1ns / 1ps
// RTC snapshot to Unix epoch converter.
// Input channel: drive snap with the raw BCD clock registers and read_ok, and
// pulse start. An item is taken at every clock edge where start is high and
// busy is low; busy is always low, so a new snapshot may enter every cycle.
// Result channel: done is high for one cycle with result valid in that same
// cycle. There is no back-pressure; the receiver must take it then.
// Pipeline: an accepted item passes through four registered stages (decode,
// year products, day sum, scale to seconds) before its result is on the
// ports. Throughput is one item per cycle, set by the four-stage pipeline.
// Config: cfg_we with cfg_index (0 chip_present, 1 min_year, 2 year_limit)
// and cfg_wdata writes a register at the clock edge; other indexes are
// ignored. Write only while no item is in flight.
// Reset: arst_n clears the pipeline valids and loads chip_present 0,
// min_year 2024, year_limit 2100. Items in flight at reset are dropped.
`include "bcd_clock_to_unix_epoch_top_assert.svh"
module bcd_clock_to_unix_epoch_top import btue_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  snap_t             snap,
	output logic              done,
	output result_t           result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [YEAR_W-1:0] cfg_wdata
);

	localparam int PIPE_DEPTH = 4;

	logic              chip_present_q;
	logic [YEAR_W-1:0] min_year_q;
	logic [YEAR_W-1:0] year_limit_q;
	cfg_t              cfg;
	logic              valid_s1;
	dec_t              dec_s1;
	logic              valid_s3;
	sum_t              sum_s3;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_present_q <= 1'b0;
			min_year_q     <= 12'd2024;
			year_limit_q   <= 12'd2100;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHIP_PRESENT: chip_present_q <= cfg_wdata[0];
				CFG_MIN_YEAR:     min_year_q     <= cfg_wdata;
				CFG_YEAR_LIMIT:   year_limit_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg.chip_present = chip_present_q;
	assign cfg.min_year     = min_year_q;
	assign cfg.year_limit   = year_limit_q;

	btue_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (start & ~busy),
		.snap     (snap),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1)
	);

	btue_days u_days (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1),
		.valid_s3 (valid_s3),
		.sum_s3   (sum_s3)
	);

	btue_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.sum_s3   (sum_s3),
		.done_q   (done),
		.result_q (result)
	);

	`BTUE_ASSERT_LAT(a_item_latency, start && !busy, PIPE_DEPTH, done)
	`BTUE_ASSERT_LAT(a_no_spurious_done, !(start && !busy), PIPE_DEPTH, !done)
	`BTUE_ASSERT_IMP(a_epoch_zero_on_error, done && (result.status != ST_OK), result.epoch_seconds == 32'd0)
	`BTUE_ASSERT_IMP(a_vlow_gated, done && (result.status == ST_ABSENT || result.status == ST_READFAIL), !result.voltage_low)

endmodule

// ----- bench/bcd_clock_to_unix_epoch_top_tb.sv -----
`timescale 1ns / 1ps
module bcd_clock_to_unix_epoch_top_tb;
	import btue_pkg::*;

	localparam int PIPE_LAT    = 4;
	localparam int CYCLE_LIMIT = 200000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	snap_t             snap;
	logic              done;
	result_t           result;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [YEAR_W-1:0] cfg_wdata;

	bcd_clock_to_unix_epoch_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.snap      (snap),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// fixed: the expected result is typed into the table, not predicted
	typedef struct {
		bit      fixed;
		result_t res;
	} pin_t;

	typedef struct {
		int      setting;
		snap_t   s;
		bit      fixed;
		result_t res;
	} row_t;

	typedef struct {
		cfg_t c;
		bit   rand_win;
		int   idle_pct;
		int   items;
	} phase_t;

	cfg_t    model_cfg;
	result_t pending_results[$];
	pin_t    pin_q[$];
	row_t    rows[$];
	cfg_t    settings[5];
	phase_t  phases[8];
	int      errors;
	int      cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch: %s got %0h want %0h", what, got, want);
		errors++;
	endtask

	function automatic int bcd_weight(logic [7:0] b);
		return int'(b[7:4]) * 10 + int'(b[3:0]);
	endfunction

	// split v (0..165) into nibbles so that hi*10+lo == v
	function automatic logic [7:0] enc_bcd(int v);
		int hi;
		logic [3:0] h4;
		logic [3:0] l4;
		hi = v / 10;
		if (hi > 15)
			hi = 15;
		h4 = hi[3:0];
		l4 = 4'(v - hi * 10);
		return {h4, l4};
	endfunction

	function automatic result_t convert_snapshot(cfg_t c, snap_t s);
		result_t r;
		int sec, mn, hr, md, mo, yr;
		longint y, era, yoe, sh, doy, doe, days, total;
		r = '0;
		if (!c.chip_present) begin
			r.status = ST_ABSENT;
		end else if (!s.read_ok) begin
			r.status = ST_READFAIL;
		end else begin
			sec = bcd_weight(s.seconds_reg & 8'h7F);
			mn  = bcd_weight(s.minutes_reg & 8'h7F);
			hr  = bcd_weight(s.hours_reg & 8'h3F);
			md  = bcd_weight(s.day_reg & 8'h3F);
			mo  = bcd_weight(s.month_reg & 8'h1F);
			yr  = bcd_weight(s.year_reg) + (s.month_reg[7] ? 1900 : 2000);
			r.voltage_low = s.seconds_reg[7];
			if (r.voltage_low) begin
				r.status = ST_VLOW;
			end else if (yr < int'(c.min_year) || yr >= int'(c.year_limit)) begin
				r.status = ST_YEAR;
			end else begin
				// March-based year: Jan/Feb (and month 0) belong to the year before
				y = (mo <= 2) ? yr - 1 : yr;
				era = y / 400;
				yoe = y - era * 400;
				sh = (mo > 2) ? mo - 3 : mo + 9;
				doy = (153 * sh + 2) / 5 + md - 1;
				doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
				days = era * 146097 + doe - 719468;
				total = days * 86400 + hr * 3600 + mn * 60 + sec;
				r.status = ST_OK;
				r.epoch_seconds = total[31:0];
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin : monitor
		result_t want;
		pin_t p;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing expected", result, 0);
				end else begin
					want = pending_results.pop_front();
					if (result.epoch_seconds !== want.epoch_seconds)
						report_mismatch("epoch_seconds", result.epoch_seconds,
							want.epoch_seconds);
					if (result.status !== want.status)
						report_mismatch("status", result.status, want.status);
					if (result.voltage_low !== want.voltage_low)
						report_mismatch("voltage_low", result.voltage_low,
							want.voltage_low);
				end
			end
			if (start && !busy) begin
				want = convert_snapshot(model_cfg, snap);
				if (pin_q.size() != 0) begin
					p = pin_q.pop_front();
					if (p.fixed)
						want = p.res;
				end
				pending_results.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHIP_PRESENT: model_cfg.chip_present <= cfg_wdata[0];
					CFG_MIN_YEAR:     model_cfg.min_year <= cfg_wdata;
					CFG_YEAR_LIMIT:   model_cfg.year_limit <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	task automatic send_snapshot(snap_t s, bit fixed, result_t res);
		pin_t p;
		p.fixed = fixed;
		p.res = res;
		pin_q.push_back(p);
		start <= 1'b1;
		snap <= s;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0 || pin_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [YEAR_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic apply_setting(cfg_t c);
		drain();
		write_reg(CFG_CHIP_PRESENT, {{(YEAR_W-1){1'b0}}, c.chip_present});
		write_reg(CFG_MIN_YEAR, c.min_year);
		write_reg(CFG_YEAR_LIMIT, c.year_limit);
		cfg_we <= 1'b0;
	endtask

	function automatic snap_t mk_snap(bit ok, logic [7:0] sec, logic [7:0] mn,
			logic [7:0] hr, logic [7:0] md, logic [7:0] mo, logic [7:0] yr);
		snap_t s;
		s.read_ok = ok;
		s.seconds_reg = sec;
		s.minutes_reg = mn;
		s.hours_reg = hr;
		s.day_reg = md;
		s.month_reg = mo;
		s.year_reg = yr;
		return s;
	endfunction

	task automatic add_row(int setting, snap_t s, bit fixed, logic [31:0] ep,
			logic [2:0] st, logic vl);
		row_t r;
		r.setting = setting;
		r.s = s;
		r.fixed = fixed;
		r.res.epoch_seconds = ep;
		r.res.status = st;
		r.res.voltage_low = vl;
		rows.push_back(r);
	endtask

	function automatic snap_t random_snapshot(cfg_t c);
		snap_t s;
		int lo, hi, yr, yy;
		logic [7:0] b;
		s = snap_t'({$urandom, $urandom});
		if ($urandom_range(0, 99) < 25)
			return s;
		// well-formed time; unused register bits stay random
		s.read_ok = ($urandom_range(0, 99) < 90);
		s.seconds_reg = enc_bcd($urandom_range(0, 59));
		s.seconds_reg[7] = ($urandom_range(0, 99) < 8);
		b = enc_bcd($urandom_range(0, 59));
		s.minutes_reg[6:0] = b[6:0];
		b = enc_bcd($urandom_range(0, 23));
		s.hours_reg[5:0] = b[5:0];
		b = enc_bcd(($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 31));
		s.day_reg[5:0] = b[5:0];
		b = enc_bcd(($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 12));
		s.month_reg[4:0] = b[4:0];
		lo = (int'(c.min_year) > 1900) ? int'(c.min_year) : 1900;
		hi = (int'(c.year_limit) - 1 < 2165) ? int'(c.year_limit) - 1 : 2165;
		if (lo <= hi && $urandom_range(0, 99) < 85)
			yr = $urandom_range(hi, lo);
		else
			yr = $urandom_range(2165, 1900);
		s.month_reg[7] = (yr < 2000);
		yy = yr - ((yr < 2000) ? 1900 : 2000);
		s.year_reg = enc_bcd(yy);
		return s;
	endfunction

	initial begin : stimulus
		int cur;
		cfg_t c;
		result_t none;
		snap_t s;
		arst_n = 1'b0;
		start = 1'b0;
		snap = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_CHIP_PRESENT;
		cfg_wdata = '0;
		errors = 0;
		cycles = 0;
		none = '0;
		model_cfg.chip_present = 1'b0;
		model_cfg.min_year = 12'd2024;
		model_cfg.year_limit = 12'd2100;

		settings[0] = '{1'b0, 12'd2024, 12'd2100}; // reset values
		settings[1] = '{1'b1, 12'd1900, 12'd2166};
		settings[2] = '{1'b1, 12'd2024, 12'd2100};
		settings[3] = '{1'b1, 12'd2165, 12'd1900}; // empty window
		settings[4] = '{1'b0, 12'd1900, 12'd2166};

		// chip absent right after reset
		add_row(0, mk_snap(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1, 0, ST_ABSENT, 0);
		add_row(0, mk_snap(1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1, 0, ST_ABSENT, 0);
		// read failure hides voltage low
		add_row(1, mk_snap(0, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00), 1, 0, ST_READFAIL, 0);
		add_row(1, mk_snap(0, 8'h80, 8'h00, 8'h00, 8'h01, 8'h01, 8'h24), 1, 0, ST_READFAIL, 0);
		add_row(1, mk_snap(1, 8'h80, 8'h00, 8'h00, 8'h01, 8'h01, 8'h24), 1, 0, ST_VLOW, 1);
		add_row(1, mk_snap(1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h81, 8'h70), 1, 0, ST_OK, 0);
		add_row(1, mk_snap(1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00), 1,
			32'd946684800, ST_OK, 0);
		add_row(1, mk_snap(1, 8'h07, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38), 1,
			32'h7FFFFFFF, ST_OK, 0);
		add_row(1, mk_snap(1, 8'h59, 8'h59, 8'h23, 8'h31, 8'h92, 8'h69), 1,
			32'hFFFFFFFF, ST_OK, 0);
		// oldest and newest years, past-2106 wrap
		add_row(1, mk_snap(1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h81, 8'h00), 0, 0, ST_OK, 0);
		add_row(1, mk_snap(1, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'hFF), 0, 0, ST_OK, 0);
		add_row(1, mk_snap(1, 8'h16, 8'h28, 8'h06, 8'h07, 8'h02, 8'hA6), 0, 0, ST_OK, 0);
		// month zero, day zero, leap day
		add_row(1, mk_snap(1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h24), 0, 0, ST_OK, 0);
		add_row(1, mk_snap(1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h24), 0, 0, ST_OK, 0);
		add_row(1, mk_snap(1, 8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'h24), 0, 0, ST_OK, 0);
		// bad nibbles everywhere, ignored bits set
		add_row(1, mk_snap(1, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF), 0, 0, ST_OK, 0);
		// window edges
		add_row(2, mk_snap(1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h23), 1, 0, ST_YEAR, 0);
		add_row(2, mk_snap(1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h24), 0, 0, ST_OK, 0);
		add_row(2, mk_snap(1, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99), 0, 0, ST_OK, 0);
		add_row(2, mk_snap(1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hA0), 1, 0, ST_YEAR, 0);
		add_row(2, mk_snap(1, 8'h80, 8'h00, 8'h00, 8'h01, 8'h01, 8'h23), 1, 0, ST_VLOW, 1);
		add_row(3, mk_snap(1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00), 1, 0, ST_YEAR, 0);
		add_row(3, mk_snap(1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hFF), 1, 0, ST_YEAR, 0);
		add_row(4, mk_snap(1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h24), 1, 0, ST_ABSENT, 0);

		phases[0] = '{settings[1], 1'b0, 0, 60};
		phases[1] = '{settings[2], 1'b0, 55, 60};
		phases[2] = '{settings[1], 1'b1, 30, 60};
		phases[3] = '{settings[1], 1'b0, 55, 60};
		phases[4] = '{settings[4], 1'b0, 30, 30};
		phases[5] = '{cfg_t'{1'b1, 12'd2165, 12'd2166}, 1'b0, 0, 60};
		phases[6] = '{cfg_t'{1'b1, 12'd1900, 12'd1901}, 1'b0, 55, 60};
		phases[7] = '{settings[1], 1'b1, 30, 90};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur = 0;
		foreach (rows[i]) begin
			if (rows[i].setting != cur) begin
				cur = rows[i].setting;
				apply_setting(settings[cur]);
			end
			send_snapshot(rows[i].s, rows[i].fixed, rows[i].res);
		end

		foreach (phases[p]) begin
			c = phases[p].c;
			if (phases[p].rand_win) begin
				c.min_year = 12'($urandom_range(2165, 1900));
				c.year_limit = 12'($urandom_range(2166, 1900));
			end
			apply_setting(c);
			for (int n = 0; n < phases[p].items; n++) begin
				s = random_snapshot(c);
				send_snapshot(s, 1'b0, none);
				if ($urandom_range(0, 99) < phases[p].idle_pct) begin
					start <= 1'b0;
					snap <= snap_t'({$urandom, $urandom});
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end
			end
		end

		drain();
		repeat (PIPE_LAT * 2) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never arrived", pending_results.size(), 0);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
